// ----- rtl/lsbs_pkg.sv -----
// ----------------------------------------------------------------------------
// LED status blink sequencer package
// Mode codes, LED bit positions and register defaults shared by the sequencer.
// ----------------------------------------------------------------------------
package lsbs_pkg;

   localparam int PERIOD_W  = 16;
   localparam int ELAPSED_W = 17;
   localparam int CSR_IDX_W = 1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(250);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_PERIOD = 1'b1;

   // Input kinds carried in tuser.
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_COMMAND = 1'b1;

   typedef enum logic [2:0] {
      MODE_OFF          = 3'd0,
      MODE_OPENING      = 3'd1,
      MODE_SHUTTING     = 3'd2,
      MODE_WIFI_ERROR   = 3'd3,
      MODE_SERVER_ERROR = 3'd4,
      MODE_BATTERY      = 3'd5,
      MODE_ALARM        = 3'd6,
      MODE_SLEEP        = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_FIRST = 2'd1,
      PHASE_DARK  = 2'd2,
      PHASE_LAST  = 2'd3
   } phase_type;

   // LED drive bits: red in bit 0, green in bit 1, blue in bit 2.
   localparam logic [2:0] LED_NONE = 3'b000;
   localparam logic [2:0] LED_R    = 3'b001;
   localparam logic [2:0] LED_G    = 3'b010;
   localparam logic [2:0] LED_B    = 3'b100;

endpackage

// ----- rtl/led_status_blink_sequencer.sv -----
// ----------------------------------------------------------------------------
// LED status blink sequencer
// Turns status commands and millisecond ticks into RGB LED drive and mode.
// ----------------------------------------------------------------------------
// Every accepted word (a tick or a status command) yields exactly one result
// word in the next cycle, and a new word is taken in every cycle as long as the
// result register is empty or being drained. The rate is set by the single
// state update path: a 17-bit saturating increment, a 17-bit compare against
// each of the two periods and a small mode/phase decision feeding the state
// and result registers.
module led_status_blink_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   // Input words.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [2:0] status_code, rest zero
   input  logic [0:0]                      req_tuser,   // [0] opcode
   // Result words.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [0] red_on, [1] green_on,
                                                        // [2] blue_on, [5:3] current_mode
   // Configuration.
   input  logic                            csr_we,
   input  logic [lsbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lsbs_pkg::PERIOD_W-1:0]   csr_wdata
);
   import lsbs_pkg::*;

   logic [PERIOD_W-1:0]  blink_period_ff, alarm_period_ff;
   mode_type             mode_ff, mode_in;
   phase_type            phase_ff, phase_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic [2:0]           led_ff, led_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic                 accept;
   logic                 blink_due, alarm_due;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_period_ff <= PERIOD_RESET;
         alarm_period_ff <= PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BLINK_PERIOD: blink_period_ff <= csr_wdata;
            CSR_ALARM_PERIOD: alarm_period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign elapsed_inc = (elapsed_ff == {ELAPSED_W{1'b1}}) ? elapsed_ff
                                                          : elapsed_ff + 1'b1;
   assign blink_due   = elapsed_inc > {1'b0, blink_period_ff};
   assign alarm_due   = elapsed_inc > {1'b0, alarm_period_ff};

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      led_in     = led_ff;
      if (accept) begin
         if (req_tuser[0] == OP_COMMAND) begin
            unique case (mode_type'(req_tdata[2:0]))
               MODE_OPENING, MODE_SHUTTING, MODE_ALARM: begin
                  mode_in    = mode_type'(req_tdata[2:0]);
                  phase_in   = PHASE_FIRST;
                  elapsed_in = '0;
                  led_in     = (mode_type'(req_tdata[2:0]) == MODE_OPENING) ? LED_G : LED_R;
               end
               MODE_WIFI_ERROR: begin
                  mode_in = MODE_WIFI_ERROR;
                  led_in  = LED_R | LED_G;
               end
               MODE_SERVER_ERROR: begin
                  mode_in = MODE_SERVER_ERROR;
                  led_in  = LED_R | LED_B;
               end
               MODE_BATTERY: begin
                  mode_in = MODE_BATTERY;
                  led_in  = LED_R;
               end
               default: begin
                  // Off and sleep commands both just go dark in the off mode.
                  mode_in = MODE_OFF;
                  led_in  = LED_NONE;
               end
            endcase
         end else begin
            elapsed_in = elapsed_inc;
            if ((mode_ff == MODE_OPENING || mode_ff == MODE_SHUTTING) && blink_due) begin
               logic [2:0] lamp;
               lamp = (mode_ff == MODE_OPENING) ? LED_G : LED_R;
               unique case (phase_ff)
                  PHASE_FIRST: begin
                     led_in     = led_ff & ~lamp;
                     phase_in   = PHASE_DARK;
                     elapsed_in = '0;
                  end
                  PHASE_DARK: begin
                     led_in     = led_ff | lamp;
                     phase_in   = PHASE_LAST;
                     elapsed_in = '0;
                  end
                  PHASE_LAST: begin
                     led_in     = LED_NONE;
                     phase_in   = PHASE_IDLE;
                     mode_in    = (mode_ff == MODE_OPENING) ? MODE_OFF : MODE_SLEEP;
                     elapsed_in = '0;
                  end
                  default: ;
               endcase
            end else if (mode_ff == MODE_ALARM && alarm_due) begin
               unique case (phase_ff)
                  PHASE_FIRST: begin
                     led_in     = led_ff & ~LED_R;
                     phase_in   = PHASE_DARK;
                     elapsed_in = '0;
                  end
                  PHASE_DARK: begin
                     led_in     = led_ff | LED_R;
                     phase_in   = PHASE_FIRST;
                     elapsed_in = '0;
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, mode_in, led_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         phase_ff     <= PHASE_IDLE;
         elapsed_ff   <= '0;
         led_ff       <= LED_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // The dark modes never light anything.
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_OFF || mode_ff == MODE_SLEEP) |-> led_ff == LED_NONE)
      else $error("LED lit in off or sleep mode");

   // Alarm only ever toggles between its two phases and shows red at most.
   a_alarm_phase: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ALARM |-> (phase_ff == PHASE_FIRST || phase_ff == PHASE_DARK))
      else $error("alarm mode left its blink phases");

   a_alarm_red: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ALARM |-> (led_ff & ~LED_R) == LED_NONE)
      else $error("alarm mode drives a color other than red");

   // A result that is still waiting keeps the block from taking a new word
   // unless the sink takes the result in the same cycle.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while result register is blocked");

   // State changes only when a word is accepted.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(mode_ff) && $stable(phase_ff) && $stable(led_ff))
      else $error("state changed without an input word");

endmodule
